// ----- sv/rris_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rris_pkg
// shared types and codes for the round-robin interval scheduler
// ----------------------------------------------------------------------------
package rris_pkg;

  localparam int TIME_W     = 32;
  localparam int SLOT_OUT_W = 3;

  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;

  typedef enum logic [0:0] {
    CMD_PUSH   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_EMPTY_RING = 2'd2
  } status_t;

endpackage

// ----- sv/rris_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rris_in_if / rris_out_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface rris_in_if import rris_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  command;
  time_t now_ms;
  time_t interval_ms;

  modport source (output valid, output command, output now_ms, output interval_ms,
                  input ready);
  modport sink   (input valid, input command, input now_ms, input interval_ms,
                  output ready);
endinterface

interface rris_out_if import rris_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      fired;
  slot_out_t task_slot;
  status_t   status;
  logic      ring_empty;

  modport source (output valid, output fired, output task_slot, output status,
                  output ring_empty, input ready);
  modport sink   (input valid, input fired, input task_slot, input status,
                  input ring_empty, output ready);
endinterface

// ----- sv/round_robin_interval_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_interval_scheduler_core
// ring of task slots with interval and due time, push and update commands
// ----------------------------------------------------------------------------
// sequence: error words go from accept straight to S_RESP; push passes
//   S_PUSH_LINK, update passes S_UPD_CMP and, when the head fires, S_UPD_WR;
//   these states come from the registered reads of the slot memories and the
//   dependent next-slot -> interval read; a new command is taken only in S_IDLE,
//   and S_RESP waits while the previous result word sits unread at the output
// reset: head, tail, count, fsm and out valid clear; slot memories not cleared
module round_robin_interval_scheduler_core import rris_pkg::*; #(
  parameter int TASK_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  rris_in_if.sink       in_ch,
  rris_out_if.source    out_ch
);

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_LINK,
    S_UPD_CMP,
    S_UPD_WR,
    S_RESP
  } state_t;

  // slot memories: interval, due time and ring link of each slot
  time_t iv_mem   [TASK_SLOTS];
  time_t due_mem  [TASK_SLOTS];
  slot_t next_mem [TASK_SLOTS];

  time_t iv_rd, due_rd;
  slot_t next_rd;

  // control and registered outputs
  state_t  state_r, state_nxt;
  slot_t   head_r, head_nxt;
  slot_t   tail_r, tail_nxt;
  cnt_t    count_r, count_nxt;
  slot_t   slot_r, slot_nxt;
  time_t   now_r, now_nxt;
  logic    res_fired_r, res_fired_nxt;
  slot_t   res_slot_r, res_slot_nxt;
  status_t res_status_r, res_status_nxt;

  logic      out_valid_r, out_valid_nxt;
  logic      out_fired_r, out_fired_nxt;
  slot_out_t out_slot_r, out_slot_nxt;
  status_t   out_status_r, out_status_nxt;
  logic      out_empty_r, out_empty_nxt;

  // memory write ports
  logic  iv_we, due_we, next_we;
  slot_t iv_waddr, due_waddr, next_waddr;
  time_t iv_wdata, due_wdata;
  slot_t next_wdata;

  logic  in_acc;
  logic  full;
  slot_t new_slot;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(TASK_SLOTS));
  assign new_slot    = count_r[SLOT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    now_nxt        = now_r;
    res_fired_nxt  = res_fired_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_fired_nxt  = out_fired_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;

    iv_we      = 1'b0;
    iv_waddr   = new_slot;
    iv_wdata   = in_ch.interval_ms;
    due_we     = 1'b0;
    due_waddr  = new_slot;
    due_wdata  = in_ch.now_ms + in_ch.interval_ms;
    next_we    = 1'b0;
    next_waddr = new_slot;
    next_wdata = (count_r == '0) ? new_slot : head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt        = in_ch.now_ms;
          res_fired_nxt  = 1'b0;
          res_slot_nxt   = '0;
          res_status_nxt = STATUS_OK;
          if (in_ch.command == CMD_PUSH) begin
            if (full) begin
              res_status_nxt = STATUS_FULL;
              state_nxt      = S_RESP;
            end else begin
              // store interval, due time and the link back to the head
              iv_we        = 1'b1;
              due_we       = 1'b1;
              next_we      = 1'b1;
              slot_nxt     = new_slot;
              res_slot_nxt = new_slot;
              state_nxt    = S_PUSH_LINK;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = STATUS_EMPTY_RING;
              state_nxt      = S_RESP;
            end else begin
              // due and next of the head are read at this edge
              res_slot_nxt = head_r;
              state_nxt    = S_UPD_CMP;
            end
          end
        end
      end
      S_PUSH_LINK: begin
        // link the new slot in after the tail
        if (count_r != '0) begin
          next_we    = 1'b1;
          next_waddr = tail_r;
          next_wdata = slot_r;
        end else begin
          head_nxt = slot_r;
        end
        tail_nxt  = slot_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_RESP;
      end
      S_UPD_CMP: begin
        if (now_r >= due_rd) begin
          // head fires, becomes the tail; interval of the new head is read
          res_fired_nxt = 1'b1;
          tail_nxt      = head_r;
          head_nxt      = next_rd;
          state_nxt     = S_UPD_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_UPD_WR: begin
        due_we    = 1'b1;
        due_waddr = head_r;
        due_wdata = now_r + iv_rd;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = res_fired_r;
          out_slot_nxt   = SLOT_OUT_W'(res_slot_r);
          out_status_nxt = res_status_r;
          out_empty_nxt  = (count_r == '0);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r       <= slot_nxt;
    now_r        <= now_nxt;
    res_fired_r  <= res_fired_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_fired_r  <= out_fired_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  // interval memory, read at the link just fetched from the next memory
  always_ff @(posedge clk) begin
    if (iv_we) begin
      iv_mem[iv_waddr] <= iv_wdata;
    end
    iv_rd <= iv_mem[next_rd];
  end

  // due time memory, read at the head
  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
    end
    due_rd <= due_mem[head_r];
  end

  // ring link memory, read at the head
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd <= next_mem[head_r];
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fired      = out_fired_r;
  assign out_ch.task_slot  = out_slot_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.ring_empty = out_empty_r;

endmodule
